// ===== rtl/wwmd_pkg.sv =====
// Shared types and constants of the wrist wake motion detector.
package wwmd_pkg;

	localparam int NUM_AXES = 3;
	localparam int SAMPLE_W = 16;
	localparam int TIME_W   = 32;
	localparam int CNT_W    = 32;
	localparam int ACC_W    = 32;
	localparam int THR_W    = 16;
	localparam int HOLD_W   = 16;
	localparam int DECAY_W  = 15;
	localparam int MAG_W    = 64;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic              RST_ENABLE    = 1'b1;
	localparam logic [THR_W-1:0]  RST_THRESHOLD = 16'd300;
	localparam logic [HOLD_W-1:0] RST_HOLDOFF   = 16'd2000;
	localparam logic [DECAY_W-1:0] RST_DECAY    = 15'd29491;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_CHECK  = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE    = 4'd0,
		REG_THRESHOLD = 4'd1,
		REG_HOLDOFF   = 4'd2,
		REG_DECAY     = 4'd3
	} cfg_reg_t;

endpackage

// ===== rtl/wwmd_if.sv =====
// Channel interfaces: input items, result items and register writes.
interface wwmd_item_if
	import wwmd_pkg::*;
();
	logic                valid;
	logic                ready;
	cmd_t                cmd;
	logic [SAMPLE_W-1:0] sample_x;
	logic [SAMPLE_W-1:0] sample_y;
	logic [SAMPLE_W-1:0] sample_z;
	logic [TIME_W-1:0]   now_ms;

	modport source(output valid, cmd, sample_x, sample_y, sample_z, now_ms, input ready);
	modport sink(input valid, cmd, sample_x, sample_y, sample_z, now_ms, output ready);
endinterface

interface wwmd_result_if
	import wwmd_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             wake;
	logic [CNT_W-1:0] wake_total;

	modport source(output valid, wake, wake_total, input ready);
	modport sink(input valid, wake, wake_total, output ready);
endinterface

interface wwmd_cfg_if
	import wwmd_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/wwmd_axis.sv =====
// One axis of the damped velocity update: difference, accumulate, Q0.15 decay, saturate.
module wwmd_axis
	import wwmd_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic [SAMPLE_W-1:0]           sample,
	input  logic signed [SAMPLE_BITS-1:0] prev,
	input  logic signed [ACC_W-1:0]       acc,
	input  logic [DECAY_W-1:0]            decay,
	output logic signed [SAMPLE_BITS-1:0] prev_next,
	output logic signed [ACC_W-1:0]       acc_next
);
	localparam int DW = SAMPLE_BITS + 1;
	localparam int SW = DW + FRAC_BITS;
	localparam int AW = ((SW > ACC_W) ? SW : ACC_W) + 1;
	localparam int PW = AW + DECAY_W + 1;

	logic [SAMPLE_BITS+SAMPLE_W-1:0] wide;
	logic signed [SAMPLE_BITS-1:0]   smp;
	logic signed [AW-1:0]            diff;
	logic signed [AW-1:0]            sum;
	logic signed [DECAY_W:0]         dec_s;
	logic signed [PW-1:0]            prod;
	logic signed [PW-1:0]            scaled;
	logic                            ovf;

	// Low SAMPLE_BITS of the field, taken as signed
	assign wide = {{SAMPLE_BITS{1'b0}}, sample};
	assign smp  = signed'(wide[SAMPLE_BITS-1:0]);

	// Change since last sample, moved to the accumulator's fixed point
	assign diff = AW'(smp) - AW'(prev);
	assign sum  = AW'(acc) + (diff <<< FRAC_BITS);

	// Decay multiply; arithmetic shift floors towards minus infinity
	assign dec_s  = signed'({1'b0, decay});
	assign prod   = PW'(sum) * PW'(dec_s);
	assign scaled = prod >>> DECAY_W;

	// Saturate to the 32-bit accumulator range
	assign ovf = !((&scaled[PW-1:ACC_W-1]) || !(|scaled[PW-1:ACC_W-1]));

	always_comb begin
		if (ovf) begin
			acc_next = scaled[PW-1] ? signed'({1'b1, {(ACC_W-1){1'b0}}})
			                        : signed'({1'b0, {(ACC_W-1){1'b1}}});
		end else begin
			acc_next = scaled[ACC_W-1:0];
		end
	end

	assign prev_next = smp;

endmodule

// ===== rtl/wrist_wake_motion_detector_top.sv =====
// Wrist wake motion detector: top level with item register, state and result register.
//
// Takes one item per clock while neither the result side nor the magnitude
// pipeline holds it back. An accepted item sits in an input register and is
// worked from there into the result register, which offers it as a result.
// Checks compare a squared magnitude that is kept in its own two-register
// pipeline (per-axis squares, then their sum); a check that follows a processed
// sample, or a register write, waits in the input register until that pipeline
// has caught up. Samples, clears and no-ops never wait for that pipeline.
// The result register takes a new item in the same cycle that its waiting
// result is taken; while a result stalls, the item behind it waits in the input register.
// Register writes are taken in any cycle.
module wrist_wake_motion_detector_top
	import wwmd_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	wwmd_item_if.sink    items,
	wwmd_result_if.source results,
	wwmd_cfg_if.sink     cfg
);
	localparam int TW = THR_W + FRAC_BITS;

	// Configuration registers
	logic                enable_q;
	logic [THR_W-1:0]    threshold_q;
	logic [HOLD_W-1:0]   holdoff_q;
	logic [DECAY_W-1:0]  decay_q;

	// Input register
	logic                s1_valid;
	cmd_t                cmd_s1;
	logic [SAMPLE_W-1:0] smp_s1 [NUM_AXES];
	logic [TIME_W-1:0]   now_s1;

	// Detector state
	logic signed [SAMPLE_BITS-1:0] prev_q [NUM_AXES];
	logic signed [ACC_W-1:0]       acc_q  [NUM_AXES];
	logic [TIME_W-1:0]             last_wake_q;
	logic [CNT_W-1:0]              wake_cnt_q;

	// Magnitude pipeline
	logic [MAG_W-1:0] sq_q [NUM_AXES];
	logic [MAG_W-1:0] mag2_q;
	logic [MAG_W-1:0] tsq_q;
	logic [1:0]       stale_q;

	// Result register
	logic             out_valid_q;
	logic             wake_q;
	logic [CNT_W-1:0] total_q;

	logic signed [SAMPLE_BITS-1:0] prev_nx [NUM_AXES];
	logic signed [ACC_W-1:0]       acc_nx  [NUM_AXES];
	logic [ACC_W-1:0]              acc_abs [NUM_AXES];
	logic [TW-1:0]                 thr_fx;
	logic [TIME_W-1:0]             elapsed;
	logic                          hold;
	logic                          move;
	logic                          go_sample;
	logic                          go_check;
	logic                          go_clear;
	logic                          wake_hit;
	logic [CNT_W-1:0]              total_nx;

	// Register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= RST_ENABLE;
			threshold_q <= RST_THRESHOLD;
			holdoff_q   <= RST_HOLDOFF;
			decay_q     <= RST_DECAY;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ENABLE:    enable_q    <= cfg.data[0];
				REG_THRESHOLD: threshold_q <= cfg.data[THR_W-1:0];
				REG_HOLDOFF:   holdoff_q   <= cfg.data[HOLD_W-1:0];
				REG_DECAY:     decay_q     <= cfg.data[DECAY_W-1:0];
				default: ;
			endcase
		end
	end

	// Flow control: a check waits while the magnitude is behind the state
	assign hold  = (cmd_s1 == CMD_CHECK) && (stale_q != 2'd0);
	assign move  = s1_valid && (!out_valid_q || results.ready) && !hold;
	assign items.ready = !s1_valid || move;

	assign go_sample = move && enable_q && (cmd_s1 == CMD_SAMPLE);
	assign go_check  = move && enable_q && (cmd_s1 == CMD_CHECK);
	assign go_clear  = move && enable_q && (cmd_s1 == CMD_CLEAR);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (items.ready) begin
			s1_valid <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			cmd_s1    <= items.cmd;
			smp_s1[0] <= items.sample_x;
			smp_s1[1] <= items.sample_y;
			smp_s1[2] <= items.sample_z;
			now_s1    <= items.now_ms;
		end
	end

	// Per-axis velocity update
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		wwmd_axis #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.FRAC_BITS  (FRAC_BITS)
		) u_axis (
			.sample   (smp_s1[a]),
			.prev     (prev_q[a]),
			.acc      (acc_q[a]),
			.decay    (decay_q),
			.prev_next(prev_nx[a]),
			.acc_next (acc_nx[a])
		);
		assign acc_abs[a] = acc_q[a][ACC_W-1] ? ACC_W'(-acc_q[a]) : acc_q[a];
	end

	// Wake decision
	assign elapsed  = now_s1 - last_wake_q;
	assign wake_hit = go_check && (mag2_q > tsq_q) && (elapsed > TIME_W'(holdoff_q));

	always_comb begin
		if (go_clear) begin
			total_nx = '0;
		end else if (wake_hit) begin
			total_nx = wake_cnt_q + CNT_W'(1);
		end else begin
			total_nx = wake_cnt_q;
		end
	end

	// Detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				prev_q[i] <= '0;
				acc_q[i]  <= '0;
			end
			last_wake_q <= '0;
			wake_cnt_q  <= '0;
		end else begin
			if (go_sample) begin
				for (int i = 0; i < NUM_AXES; i++) begin
					prev_q[i] <= prev_nx[i];
					acc_q[i]  <= acc_nx[i];
				end
			end
			if (go_clear) begin
				for (int i = 0; i < NUM_AXES; i++) begin
					prev_q[i] <= '0;
					acc_q[i]  <= '0;
				end
				last_wake_q <= '0;
			end
			if (wake_hit) begin
				last_wake_q <= now_s1;
			end
			wake_cnt_q <= total_nx;
		end
	end

	// Squares, then their sum; a clear zeroes both at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				sq_q[i] <= '0;
			end
			mag2_q <= '0;
		end else if (go_clear) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				sq_q[i] <= '0;
			end
			mag2_q <= '0;
		end else begin
			for (int i = 0; i < NUM_AXES; i++) begin
				sq_q[i] <= MAG_W'(acc_abs[i]) * MAG_W'(acc_abs[i]);
			end
			mag2_q <= sq_q[0] + sq_q[1] + sq_q[2];
		end
	end

	// Squared threshold, refreshed every cycle
	assign thr_fx = TW'(threshold_q) << FRAC_BITS;

	always_ff @(posedge clk) begin
		tsq_q <= MAG_W'(thr_fx) * MAG_W'(thr_fx);
	end

	// Cycles until the magnitude and squared threshold match the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q <= 2'd1;
		end else if (go_sample || cfg.valid) begin
			stale_q <= 2'd2;
		end else if (stale_q != 2'd0) begin
			stale_q <= stale_q - 2'd1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			wake_q  <= wake_hit;
			total_q <= total_nx;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.wake       = wake_q;
	assign results.wake_total = total_q;

endmodule

// ===== rtl/wwmd_checker.sv =====
// Port-level checks of the wrist wake motion detector, bound to the top level.
module wwmd_checker
	import wwmd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             out_wake,
	input logic [CNT_W-1:0] out_total
);
	logic             in_beat;
	logic             out_beat;
	logic [1:0]       pending_q;
	logic [CNT_W-1:0] last_total_q;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Items taken but not yet delivered, and the last delivered count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			last_total_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(in_beat) - 2'(out_beat);
			if (out_beat) begin
				last_total_q <= out_total;
			end
		end
	end

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat withdrawn while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result offered with no item outstanding");

	a_wake_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && out_wake |->
			out_total == last_total_q + CNT_W'(1) || out_total == CNT_W'(1))
		else $error("wake beat without count step");

	a_quiet_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && !out_wake |-> out_total == last_total_q || out_total == '0)
		else $error("wake count moved without a wake");

endmodule

bind wrist_wake_motion_detector_top wwmd_checker u_wwmd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (items.valid),
	.in_ready (items.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_wake (results.wake),
	.out_total(results.wake_total)
);

// ===== test/wrist_wake_motion_detector_top_tb.sv =====
// Testbench of the wrist wake motion detector: random and directed items, checked beat by beat.
module wrist_wake_motion_detector_top_tb
	import wwmd_pkg::*;
();

	localparam int VEL_FRAC       = 8;
	localparam int RX_HOLD_CYCLES = 200;
	localparam int TAIL_CYCLES    = 8;
	localparam int RUN_LIMIT      = 2_000_000;

	localparam logic signed [63:0] VEL_MAX = 64'sd2147483647;
	localparam logic signed [63:0] VEL_MIN = -64'sd2147483648;

	// Index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'hB;

	typedef struct packed {
		logic             wake;
		logic [CNT_W-1:0] total;
	} wake_report_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic clk;
	logic arst_n;

	wwmd_item_if   items_if ();
	wwmd_result_if res_if ();
	wwmd_cfg_if    cfg_if ();

	wrist_wake_motion_detector_top #(
		.SAMPLE_BITS(SAMPLE_W),
		.FRAC_BITS  (VEL_FRAC)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_if),
		.results(res_if),
		.cfg    (cfg_if)
	);

	// Model copy of the registers and of the motion state
	logic                       det_en;
	logic [THR_W-1:0]           thr_mg;
	logic [HOLD_W-1:0]          hold_ms;
	logic [DECAY_W-1:0]         decay_q15;
	logic signed [SAMPLE_W-1:0] axis_prev [NUM_AXES];
	logic signed [ACC_W-1:0]    axis_vel [NUM_AXES];
	logic [TIME_W-1:0]          last_wake;
	logic [CNT_W-1:0]           wake_tally;

	wake_report_t wake_reports [$];
	int unsigned  report_faults;

	// Stimulus state: wrist pose per axis and a millisecond clock
	logic signed [SAMPLE_W-1:0] pose [NUM_AXES];
	logic [TIME_W-1:0]          wall_ms;
	int unsigned                tx_burst_left;
	logic                       tx_no_gaps;

	logic rx_hold;
	event rx_hold_go;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("wrist_wake_motion_detector_top_tb: done, errors");
		$finish;
	end

	function automatic void zero_motion_state();
		for (int i = 0; i < NUM_AXES; i++) begin
			axis_prev[i] = '0;
			axis_vel[i]  = '0;
		end
		last_wake  = '0;
		wake_tally = '0;
	endfunction

	// Works one item through the motion state and returns the report it causes
	function automatic wake_report_t detect_step(input cmd_t c, input logic [SAMPLE_W-1:0] sx,
			input logic [SAMPLE_W-1:0] sy, input logic [SAMPLE_W-1:0] sz,
			input logic [TIME_W-1:0] now);
		logic signed [SAMPLE_W-1:0] smp [NUM_AXES];
		logic signed [63:0] diff;
		logic signed [63:0] sum;
		logic signed [63:0] prod;
		logic signed [63:0] vel;
		logic signed [63:0] sq;
		logic [MAG_W-1:0]   mag2;
		logic [MAG_W-1:0]   lim;
		logic [TIME_W-1:0]  since;
		wake_report_t       rep;
		smp[0] = sx;
		smp[1] = sy;
		smp[2] = sz;
		rep.wake = 1'b0;
		if (det_en) begin
			case (c)
				CMD_SAMPLE: begin
					for (int i = 0; i < NUM_AXES; i++) begin
						diff = 64'(smp[i]) - 64'(axis_prev[i]);
						sum  = 64'(axis_vel[i]) + (diff <<< VEL_FRAC);
						prod = sum * 64'($signed({1'b0, decay_q15}));
						// arithmetic shift floors toward minus infinity
						vel  = prod >>> 15;
						if (vel > VEL_MAX)
							vel = VEL_MAX;
						else if (vel < VEL_MIN)
							vel = VEL_MIN;
						axis_vel[i]  = vel[ACC_W-1:0];
						axis_prev[i] = smp[i];
					end
				end
				CMD_CHECK: begin
					mag2 = '0;
					for (int i = 0; i < NUM_AXES; i++) begin
						sq   = 64'(axis_vel[i]) * 64'(axis_vel[i]);
						mag2 = mag2 + MAG_W'(sq);
					end
					lim   = 64'(thr_mg) << VEL_FRAC;
					since = now - last_wake;
					if (mag2 > lim * lim && since > 32'(hold_ms)) begin
						last_wake  = now;
						wake_tally = wake_tally + CNT_W'(1);
						rep.wake   = 1'b1;
					end
				end
				CMD_CLEAR: zero_motion_state();
				default: ;
			endcase
		end
		rep.total = wake_tally;
		return rep;
	endfunction

	// Offers one item in bursts with random gaps and waits for its beat
	task automatic send_item(input cmd_t c, input logic [SAMPLE_W-1:0] sx,
			input logic [SAMPLE_W-1:0] sy, input logic [SAMPLE_W-1:0] sz,
			input logic [TIME_W-1:0] now);
		int unsigned gap;
		if (tx_burst_left == 0) begin
			tx_burst_left = $urandom_range(1, 24);
			gap = (tx_no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
			if (gap != 0) begin
				items_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		items_if.valid    <= 1'b1;
		items_if.cmd      <= c;
		items_if.sample_x <= sx;
		items_if.sample_y <= sy;
		items_if.sample_z <= sz;
		items_if.now_ms   <= now;
		@(posedge clk);
		while (!items_if.ready) @(posedge clk);
		tx_burst_left--;
		wake_reports.push_back(detect_step(c, sx, sy, sz, now));
	endtask

	// Stops offering items and waits until every report is in
	task automatic wait_reports_done();
		items_if.valid <= 1'b0;
		tx_burst_left = 0;
		@(posedge clk);
		while (wake_reports.size() != 0) @(posedge clk);
	endtask

	// Leaves valid high so that writes can follow back to back
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		case (idx)
			REG_ENABLE:    det_en    = val[0];
			REG_THRESHOLD: thr_mg    = val[THR_W-1:0];
			REG_HOLDOFF:   hold_ms   = val[HOLD_W-1:0];
			REG_DECAY:     decay_q15 = val[DECAY_W-1:0];
			default: ;
		endcase
	endtask

	// Unused upper bits of enable and decay carry random values
	task automatic set_config(input logic en, input logic [THR_W-1:0] thr,
			input logic [HOLD_W-1:0] hold, input logic [DECAY_W-1:0] decay);
		logic [CFG_DATA_W-1:0] word;
		word    = CFG_DATA_W'($urandom);
		word[0] = en;
		write_reg(REG_ENABLE, word);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_HOLDOFF, hold);
		word = CFG_DATA_W'($urandom);
		word[DECAY_W-1:0] = decay;
		write_reg(REG_DECAY, word);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly wrist motion with flicks and slams, timed checks, some clears and no-ops
	task automatic random_item();
		int unsigned pick;
		int          span;
		int          nudge;
		logic [SAMPLE_W-1:0] v [NUM_AXES];
		pick = $urandom_range(0, 99);
		span = int'(thr_mg) * 2 + 600;
		if (pick < 56) begin
			if ($urandom_range(0, 9) == 0) begin
				// full-scale swing on every axis
				for (int i = 0; i < NUM_AXES; i++)
					pose[i] = (pose[i] < 0) ? 16'sh7FFF : 16'sh8000;
			end else begin
				for (int i = 0; i < NUM_AXES; i++) begin
					case ($urandom_range(0, 9))
						0: pose[i] = SAMPLE_W'($urandom);
						1, 2: begin
							nudge   = int'($urandom_range(0, 2 * span)) - span;
							pose[i] = pose[i] + SAMPLE_W'(nudge);
						end
						default: ;
					endcase
				end
			end
			for (int i = 0; i < NUM_AXES; i++)
				v[i] = pose[i] + SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
			send_item(CMD_SAMPLE, v[0], v[1], v[2], $urandom);
		end else if (pick < 90) begin
			if ($urandom_range(0, 9) == 0)
				wall_ms = $urandom;
			else
				wall_ms = wall_ms + $urandom_range(0, int'(hold_ms) * 2 / 3 + 64);
			send_item(CMD_CHECK, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
				SAMPLE_W'($urandom), wall_ms);
		end else if (pick < 94) begin
			send_item(CMD_CLEAR, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
				SAMPLE_W'($urandom), $urandom);
		end else begin
			send_item(CMD_NOP, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
				SAMPLE_W'($urandom), $urandom);
		end
	endtask

	task automatic run_phase(input logic en, input logic [THR_W-1:0] thr,
			input logic [HOLD_W-1:0] hold, input logic [DECAY_W-1:0] decay, input int n);
		wait_reports_done();
		set_config(en, thr, hold, decay);
		repeat (n) random_item();
	endtask

	// Reset settings: full-scale samples, holdoff edges across the wrap, no-op and clear
	task automatic test_command_extremes();
		send_item(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'h0);
		send_item(CMD_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF);
		send_item(CMD_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0);
		send_item(CMD_CHECK, 16'h0000, 16'h0000, 16'h0000, 32'd2000);
		send_item(CMD_CHECK, 16'h8000, 16'h8000, 16'h8000, 32'd2001);
		send_item(CMD_CHECK, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd2002);
		send_item(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'h0);
		send_item(CMD_CHECK, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
		send_item(CMD_CHECK, 16'h0000, 16'h0000, 16'h0000, 32'd2000);
		send_item(CMD_NOP, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
			SAMPLE_W'($urandom), $urandom);
		send_item(CMD_CLEAR, 16'hFFFF, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(CMD_CHECK, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
	endtask

	// Unmapped index, zero threshold and holdoff, decay extremes, disabled block
	task automatic test_register_edges();
		wait_reports_done();
		write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
		set_config(1'b1, '0, '0, '1);
		send_item(CMD_CHECK, 16'h0000, 16'h0000, 16'h0000, 32'd5);
		send_item(CMD_SAMPLE, 16'h0001, 16'h0000, 16'h0000, 32'd0);
		send_item(CMD_CHECK, 16'h0000, 16'h0000, 16'h0000, 32'd6);
		send_item(CMD_CHECK, 16'h0000, 16'h0000, 16'h0000, 32'd6);
		wait_reports_done();
		set_config(1'b1, '1, '1, '0);
		send_item(CMD_SAMPLE, 16'h7FFF, 16'h8000, 16'h7FFF, 32'd0);
		send_item(CMD_CHECK, 16'h0000, 16'h0000, 16'h0000, 32'h1234_5678);
		wait_reports_done();
		set_config(1'b0, RST_THRESHOLD, RST_HOLDOFF, RST_DECAY);
		send_item(CMD_SAMPLE, 16'h8000, 16'h7FFF, 16'h8000, 32'd0);
		send_item(CMD_CHECK, 16'h0000, 16'h0000, 16'h0000, 32'h8000_0000);
		send_item(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 32'd0);
		send_item(CMD_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		wait_reports_done();
		set_config(1'b1, RST_THRESHOLD, RST_HOLDOFF, RST_DECAY);
		send_item(CMD_SAMPLE, 16'h4000, 16'hC000, 16'h0100, 32'd0);
		send_item(CMD_CHECK, 16'h0000, 16'h0000, 16'h0000, 32'h8000_0000);
	endtask

	// Phases of random traffic under different settings
	task automatic test_random_traffic();
		run_phase(1'b1, RST_THRESHOLD, RST_HOLDOFF, RST_DECAY, 260);
		run_phase(1'b1, '0, '0, '1, 130);
		run_phase(1'b1, '1, '1, '1, 130);
		run_phase(1'b1, 16'd100, 16'd500, '0, 80);
		run_phase(1'b0, THR_W'($urandom), HOLD_W'($urandom), DECAY_W'($urandom), 60);
		repeat (3)
			run_phase(1'b1, THR_W'($urandom_range(20, 1500)),
				HOLD_W'($urandom_range(0, 3000)),
				DECAY_W'($urandom_range(20000, 32767)), 110);
	endtask

	// Long result stall while items keep coming, then a pause until all reports are in, then more items
	task automatic test_result_backpressure();
		wait_reports_done();
		set_config(1'b1, THR_W'($urandom_range(100, 600)), HOLD_W'($urandom_range(0, 2500)),
			RST_DECAY);
		-> rx_hold_go;
		tx_no_gaps = 1'b1;
		repeat (40) random_item();
		tx_no_gaps = 1'b0;
		wait_reports_done();
		repeat (60) random_item();
	endtask

	// Long receiver hold-off, counted here
	initial begin
		rx_hold <= 1'b0;
		forever begin
			@(rx_hold_go);
			rx_hold <= 1'b1;
			repeat (RX_HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	// Result side: check each beat, then pick the next ready
	initial begin : result_side
		rx_mode_t     rx_mode;
		int unsigned  mode_left;
		int unsigned  rx_tick;
		logic         rx_open;
		wake_report_t want;
		res_if.ready <= 1'b0;
		rx_mode   = RX_FREE;
		mode_left = 64;
		rx_tick   = 0;
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				if (wake_reports.size() == 0) begin
					report_faults++;
					if (report_faults <= 10)
						$display("%0t: result beat with nothing pending: wake %0b total %0d",
							$time, res_if.wake, res_if.wake_total);
				end else begin
					want = wake_reports.pop_front();
					if (res_if.wake !== want.wake || res_if.wake_total !== want.total) begin
						report_faults++;
						if (report_faults <= 10)
							$display("%0t: wake %0b/%0b total %0d/%0d (expected/actual)",
								$time, want.wake, res_if.wake, want.total,
								res_if.wake_total);
					end
				end
			end
			// switch stall pattern now and then
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 256);
			end
			mode_left--;
			rx_tick++;
			case (rx_mode)
				RX_FREE:   rx_open = 1'b1;
				RX_COIN:   rx_open = 1'($urandom_range(0, 1));
				RX_SPARSE: rx_open = ($urandom_range(0, 3) == 0);
				default:   rx_open = (rx_tick % 5) < 2;
			endcase
			res_if.ready <= rx_open && !rx_hold;
		end
	end

	// Sequence of tests
	initial begin
		arst_n            <= 1'b0;
		items_if.valid    <= 1'b0;
		items_if.cmd      <= CMD_NOP;
		items_if.sample_x <= '0;
		items_if.sample_y <= '0;
		items_if.sample_z <= '0;
		items_if.now_ms   <= '0;
		cfg_if.valid      <= 1'b0;
		cfg_if.index      <= REG_ENABLE;
		cfg_if.data       <= '0;
		det_en    = RST_ENABLE;
		thr_mg    = RST_THRESHOLD;
		hold_ms   = RST_HOLDOFF;
		decay_q15 = RST_DECAY;
		zero_motion_state();
		for (int i = 0; i < NUM_AXES; i++)
			pose[i] = '0;
		wall_ms       = '0;
		tx_burst_left = 0;
		tx_no_gaps    = 1'b0;
		report_faults = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_command_extremes();
		test_register_edges();
		test_random_traffic();
		test_result_backpressure();
		wait_reports_done();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (report_faults == 0 && wake_reports.size() == 0)
			$display("wrist_wake_motion_detector_top_tb: done, clean");
		else
			$display("wrist_wake_motion_detector_top_tb: done, errors");
		$finish;
	end

endmodule
